### hdl/lsap_pkg.sv
`timescale 1ns / 1ps

package lsap_pkg;

	// one input item
	typedef struct packed {
		logic [1:0]        op;
		logic [6:0]        index;
		logic signed [15:0] value;
		logic              last;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [15:0] prior;
		logic [5:0]  action_number;
		logic        final_res;
	} out_item_t;

	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_STATE  = 2'd1;
	localparam logic [1:0] OP_ACTION = 2'd2;

	localparam logic REG_BIAS = 1'b0;
	localparam logic REG_INV_TEMP = 1'b1;

	localparam logic signed [31:0] BIAS_RESET = 32'sd0;
	localparam logic [15:0] INV_TEMP_RESET = 16'd256;
	localparam logic signed [31:0] LOGIT_MIN = 32'sh8000_0000;
	localparam logic [15:0] PRIOR_ONE = 16'hFFFF;

	// divider numerator width: (e << 16) + sum / 2 stays below 2^33
	localparam int NUM_W = 34;

	// exp(-k) for the integer part, Q1.16
	function automatic logic [16:0] exp_int(input logic [3:0] k);
		logic [16:0] r;
		case (k)
			4'd0: r = 17'd65536;
			4'd1: r = 17'd24109;
			4'd2: r = 17'd8869;
			4'd3: r = 17'd3263;
			4'd4: r = 17'd1200;
			4'd5: r = 17'd442;
			4'd6: r = 17'd162;
			4'd7: r = 17'd60;
			4'd8: r = 17'd22;
			4'd9: r = 17'd8;
			4'd10: r = 17'd3;
			4'd11: r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// exp of the top fraction nibble
	function automatic logic [16:0] exp_hi(input logic [3:0] f);
		logic [16:0] r;
		case (f)
			4'd0: r = 17'd65536;
			4'd1: r = 17'd61565;
			4'd2: r = 17'd57835;
			4'd3: r = 17'd54331;
			4'd4: r = 17'd51039;
			4'd5: r = 17'd47947;
			4'd6: r = 17'd45042;
			4'd7: r = 17'd42313;
			4'd8: r = 17'd39750;
			4'd9: r = 17'd37341;
			4'd10: r = 17'd35079;
			4'd11: r = 17'd32954;
			4'd12: r = 17'd30957;
			4'd13: r = 17'd29081;
			4'd14: r = 17'd27319;
			default: r = 17'd25664;
		endcase
		return r;
	endfunction

	// exp of the second fraction nibble
	function automatic logic [16:0] exp_lo(input logic [3:0] f);
		logic [16:0] r;
		case (f)
			4'd0: r = 17'd65536;
			4'd1: r = 17'd65280;
			4'd2: r = 17'd65026;
			4'd3: r = 17'd64772;
			4'd4: r = 17'd64520;
			4'd5: r = 17'd64268;
			4'd6: r = 17'd64018;
			4'd7: r = 17'd63768;
			4'd8: r = 17'd63520;
			4'd9: r = 17'd63272;
			4'd10: r = 17'd63025;
			4'd11: r = 17'd62780;
			4'd12: r = 17'd62535;
			4'd13: r = 17'd62291;
			4'd14: r = 17'd62048;
			default: r = 17'd61806;
		endcase
		return r;
	endfunction

endpackage

### hdl/linear_softmax_action_priors_unit.sv
`timescale 1ns / 1ps
// Weight write items complete on acceptance; feature items pass S_WRD and S_ACC, then S_LOGIT,
// S_SCALE and S_STORE when they complete an action. The last item then walks the logit memory
// twice: for the exp sum, then for exp and the bit-serial divider, one prior per action.
// Results appear as single-cycle strobes; the receiver cannot stall them.
// Reset clears weights (valid bits), sums, max, count, state and config; logits need no reset.
module linear_softmax_action_priors_unit #(
	parameter int STATE_FEATURES = 64,
	parameter int ACTION_FEATURES = 16,
	parameter int MAX_ACTIONS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  lsap_pkg::in_item_t   item,
	output logic                 res_strobe,
	output lsap_pkg::out_item_t  res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [31:0]          cfg_data
);
	import lsap_pkg::*;

	localparam int WD = STATE_FEATURES + ACTION_FEATURES;
	localparam int WAW = $clog2(WD);
	localparam int CNT_W = $clog2(MAX_ACTIONS + 1);
	localparam int AW = $clog2(MAX_ACTIONS);
	localparam int SUM_W = 17 + $clog2(MAX_ACTIONS);

	typedef enum logic [3:0] {
		S_IDLE, S_WRD, S_ACC, S_LOGIT, S_SCALE, S_STORE, S_EMIT0,
		S_ERD, S_ED, S_EM1, S_EM2, S_ER, S_DWAIT
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic signed [31:0] bias_q;
	logic [15:0] inv_q;
	logic signed [31:0] state_sum_q, action_sum_q, max_q;
	logic [CNT_W-1:0] count_q, i_q;
	logic pass_q;
	logic feat_ok_q;
	logic signed [31:0] prod_q;
	logic signed [31:0] logit_q;
	logic signed [48:0] scl_q;
	logic [31:0] d_q;
	logic zero_q;
	logic [33:0] m1_q, m2_q;
	logic [SUM_W-1:0] sum_q;
	out_item_t res_q;
	logic res_strobe_q;

	// logit memory
	logic signed [31:0] logit_mem [MAX_ACTIONS];
	logic signed [31:0] lrd_q;
	logic lwe;

	// weight memory signals
	logic accept;
	logic w_we;
	logic [WAW-1:0] w_addr, w_raddr;
	logic signed [15:0] w_rdata;
	logic feat_ok;

	// derived arithmetic
	logic signed [32:0] acc_in, acc_next;
	logic signed [31:0] acc_sat;
	logic signed [33:0] logit_sum;
	logic signed [40:0] scl_sh;
	logic signed [31:0] scaled;
	logic [16:0] e1, e;
	logic div_start, div_done;
	logic [NUM_W-1:0] div_num, div_quo;
	logic [CNT_W+5:0] i_ext;
	logic last_i;

	assign accept = start && !busy;
	assign busy = state_q != S_IDLE;
	assign cfg_ready = 1'b1;

	// weight address and range check from the incoming item
	always_comb begin
		w_we = accept && item.op == OP_WEIGHT && int'(item.index) < WD;
		w_addr = WAW'(item.index);
		w_raddr = '0;
		feat_ok = 1'b0;
		if (item.op == OP_STATE && int'(item.index) < STATE_FEATURES) begin
			w_raddr = WAW'(item.index);
			feat_ok = 1'b1;
		end else if (item.op == OP_ACTION && int'(item.index) < ACTION_FEATURES) begin
			w_raddr = WAW'(STATE_FEATURES + int'(item.index));
			feat_ok = 1'b1;
		end
	end

	lsap_wmem #(.DEPTH(WD), .AW(WAW)) u_wmem (
		.clk(clk), .arst_n(arst_n), .we(w_we), .waddr(w_addr),
		.wdata(item.value), .raddr(w_raddr), .rdata(w_rdata)
	);

	// saturating accumulate into the selected sum
	assign acc_in = (item_q.op == OP_STATE) ? 33'(state_sum_q) : 33'(action_sum_q);
	assign acc_next = acc_in + 33'(prod_q);
	assign acc_sat = (acc_next > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
		(acc_next < -33'sh0_8000_0000) ? LOGIT_MIN : acc_next[31:0];

	assign logit_sum = 34'(bias_q) + 34'(state_sum_q) + 34'(action_sum_q);
	assign scl_sh = scl_q[48:8];
	assign scaled = (scl_sh > 41'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
		(scl_sh < -41'sh0_8000_0000) ? LOGIT_MIN : scl_sh[31:0];

	// exp rounding steps
	assign e1 = 17'((m1_q + 34'd32768) >> 16);
	assign e = zero_q ? 17'd0 : 17'((m2_q + 34'd32768) >> 16);

	assign div_start = state_q == S_ER && pass_q;
	assign div_num = NUM_W'({e, 16'h0000}) + NUM_W'(sum_q >> 1);

	lsap_divider #(.NW(NUM_W), .DW(SUM_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(sum_q), .done(div_done), .quo(div_quo)
	);

	assign i_ext = {6'd0, i_q};
	assign last_i = i_q == count_q - 1'b1;
	assign lwe = state_q == S_STORE && int'(count_q) < MAX_ACTIONS;

	// logit memory write and registered read
	always_ff @(posedge clk) begin
		if (lwe) logit_mem[count_q[AW-1:0]] <= scaled;
		lrd_q <= logit_mem[i_q[AW-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= BIAS_RESET;
			inv_q <= INV_TEMP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BIAS: bias_q <= cfg_data;
				REG_INV_TEMP: inv_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// sequencer: accumulate, complete actions, then emit priors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			state_sum_q <= '0;
			action_sum_q <= '0;
			max_q <= LOGIT_MIN;
			count_q <= '0;
			i_q <= '0;
			pass_q <= 1'b0;
			res_strobe_q <= 1'b0;
		end else begin
			res_strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q <= item;
						feat_ok_q <= feat_ok;
						if (item.op == OP_STATE || item.op == OP_ACTION) state_q <= S_WRD;
					end
				end
				S_WRD: begin
					prod_q <= feat_ok_q ? 32'(w_rdata * item_q.value) : 32'sd0;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (item_q.op == OP_STATE) begin
						state_sum_q <= acc_sat;
						state_q <= S_IDLE;
					end else begin
						action_sum_q <= acc_sat;
						if (int'(item_q.index) == ACTION_FEATURES - 1 || item_q.last)
							state_q <= S_LOGIT;
						else
							state_q <= S_IDLE;
					end
				end
				S_LOGIT: begin
					logit_q <= (logit_sum > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
						(logit_sum < -34'sh0_8000_0000) ? LOGIT_MIN : logit_sum[31:0];
					action_sum_q <= '0;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					scl_q <= 49'(logit_q) * $signed({1'b0, inv_q});
					state_q <= S_STORE;
				end
				S_STORE: begin
					if (lwe) begin
						count_q <= count_q + 1'b1;
						if (scaled > max_q) max_q <= scaled;
					end
					state_q <= item_q.last ? S_EMIT0 : S_IDLE;
				end
				S_EMIT0: begin
					i_q <= '0;
					pass_q <= 1'b0;
					sum_q <= '0;
					if (count_q == CNT_W'(1)) begin
						res_strobe_q <= 1'b1;
						res_q.prior <= PRIOR_ONE;
						res_q.action_number <= '0;
						res_q.final_res <= 1'b1;
					end
					if (count_q == '0 || count_q == CNT_W'(1)) begin
						state_sum_q <= '0;
						max_q <= LOGIT_MIN;
						count_q <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ERD;
					end
				end
				S_ERD: state_q <= S_ED;
				S_ED: begin
					d_q <= 32'(max_q - lrd_q);
					state_q <= S_EM1;
				end
				S_EM1: begin
					zero_q <= d_q[31:16] >= 16'd12;
					m1_q <= exp_int(d_q[19:16]) * exp_hi(d_q[15:12]);
					state_q <= S_EM2;
				end
				S_EM2: begin
					m2_q <= e1 * exp_lo(d_q[11:8]);
					state_q <= S_ER;
				end
				S_ER: begin
					if (pass_q) begin
						state_q <= S_DWAIT;
					end else begin
						sum_q <= sum_q + SUM_W'(e);
						if (last_i) begin
							i_q <= '0;
							pass_q <= 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
						end
						state_q <= S_ERD;
					end
				end
				S_DWAIT: begin
					if (div_done) begin
						res_strobe_q <= 1'b1;
						res_q.prior <= (div_quo > NUM_W'(65535)) ? PRIOR_ONE : div_quo[15:0];
						res_q.action_number <= i_ext[5:0];
						res_q.final_res <= last_i;
						if (last_i) begin
							state_sum_q <= '0;
							max_q <= LOGIT_MIN;
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_strobe = res_strobe_q;
	assign res = res_q;

endmodule

### hdl/lsap_wmem.sv
`timescale 1ns / 1ps

module lsap_wmem #(
	parameter int DEPTH = 80,
	parameter int AW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic signed [15:0]  wdata,
	input  logic [AW-1:0]       raddr,
	output logic signed [15:0]  rdata
);
	import lsap_pkg::*;

	logic signed [15:0] mem [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	logic signed [15:0] rd_q;
	logic               rd_valid_q;

	// mark written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) valid_q[waddr] <= 1'b1;
			rd_valid_q <= valid_q[raddr];
		end
	end

	// write and registered read of the array
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign rdata = rd_valid_q ? rd_q : 16'sd0;

endmodule

### hdl/lsap_divider.sv
`timescale 1ns / 1ps

module lsap_divider #(
	parameter int NW = 34,
	parameter int DW = 23
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	import lsap_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          ge;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign ge = rem_sh >= {1'b0, den_q};

	// one quotient bit per cycle, shifted into the numerator register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo = num_q;

endmodule
